// File: src/ccep_pkg.sv
// ----------------------------------------------------------------------------
// ccep_pkg
// Shared types and constants of the chunk eviction policy block.
// ----------------------------------------------------------------------------
`default_nettype none

package ccep_pkg;

    localparam int DEF_CHUNKS    = 32;
    localparam int DEF_SIZE_BITS = 32;

    // request codes
    localparam logic [2:0] REQ_REGISTER = 3'd0;
    localparam logic [2:0] REQ_DELETE   = 3'd1;
    localparam logic [2:0] REQ_TOUCH    = 3'd2;
    localparam logic [2:0] REQ_SWAP_OUT = 3'd3;
    localparam logic [2:0] REQ_SWAP_IN  = 3'd4;

    // configuration register indexes
    localparam logic CFG_MEMORY_LIMIT      = 1'b0;
    localparam logic CFG_SWAP_OUT_FRACTION = 1'b1;

    localparam logic [31:0] LIMIT_RESET = 32'd0;
    localparam logic [8:0]  FRAC_RESET  = 9'd192;
    localparam logic [8:0]  FRAC_FULL   = 9'd256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INS_A,
        ST_INS_B,
        ST_DEL,
        ST_TCH,
        ST_TCH_RD,
        ST_SWI,
        ST_CALC_TGT,
        ST_CALC_NEED,
        ST_SWEEP_INIT,
        ST_SWEEP,
        ST_EMIT,
        ST_RESP_OK,
        ST_RESP_FAIL
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_REG_FIRST,
        OP_REG_START,
        OP_RD_ID,
        OP_RD_HEAD,
        OP_INS_A,
        OP_INS_B,
        OP_DEL,
        OP_TCH_UNLINK,
        OP_SWI,
        OP_CALC_TGT,
        OP_CALC_NEED,
        OP_SWEEP_INIT,
        OP_SWEEP_STEP,
        OP_COMMIT,
        OP_EMIT,
        OP_RESP_OK,
        OP_RESP_FAIL
    } t_dp_op;

    typedef struct packed {
        logic is_reg;
        logic is_del;
        logic is_tch;
        logic is_out;
        logic is_in;
        logic bad_id;
        logic id_valid;
        logic id_swapped;
        logic head_is_id;
        logic empty;
        logic min_gt_limit;
        logic need_zero;
        logic sum_reached;
        logic wrap;
        logic cnt_zero;
        logic emit_last;
    } t_dp_status;

endpackage

`default_nettype wire

// File: src/cyclic_chunk_eviction_policy.sv
// ----------------------------------------------------------------------------
// cyclic_chunk_eviction_policy
// Recency ring of memory chunks with a sweep hand for swap-out selection.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: a transaction is taken on a rising edge with start high
//    and busy low; req_type, chunk_id, chunk_size, min_free are sampled then.
//  - Result channel: each result is shown for one cycle with o_valid high.
//    The receiver cannot stall; o_last marks the final result of a request.
//  - Config: i_cfg_we writes i_cfg_data into register i_cfg_idx
//    (0 memory limit, 1 swap-out fraction); write only while idle.
//  - Paths: requests settled at decode (rejects, first register, touch of
//    head) go straight to the response; swap-in and delete pass through
//    SWI or DEL; register through INS_A and INS_B; touch through unlink, head
//    reread and relink, via the link memories (one read, one write port).
//  - Swap-out: setup (decode, target multiply, need, hand load), a sweep of
//    ring entries and a commit, then the swept entries are walked again
//    while emitting; zero need, a wrap or no resident pick gives a response.
//  - Throughput: one request at a time; busy drops in the final result cycle.
//  - Reset (synchronous, active low): ring empty, totals zero, config at
//    defaults; the link and size memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module cyclic_chunk_eviction_policy import ccep_pkg::*; #(
    parameter int CHUNKS    = DEF_CHUNKS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [4:0]  i_chunk_id,
    input  wire logic [31:0] i_chunk_size,
    input  wire logic [31:0] i_min_free,
    output logic             o_valid,
    output logic [4:0]       o_evicted_chunk,
    output logic             o_has_chunk,
    output logic             o_ok,
    output logic             o_last,
    output logic [31:0]      o_used_bytes,
    output logic [31:0]      o_swapped_bytes
);

    t_dp_op     op;     // command from controller
    t_dp_status st;     // status back from datapath

    ccep_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_st    (st),
        .o_op    (op),
        .o_busy  (busy)
    );

    ccep_dp #(
        .CHUNKS    (CHUNKS),
        .SIZE_BITS (SIZE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_chunk_id      (i_chunk_id),
        .i_chunk_size    (i_chunk_size),
        .i_min_free      (i_min_free),
        .i_op            (op),
        .o_st            (st),
        .o_valid         (o_valid),
        .o_evicted_chunk (o_evicted_chunk),
        .o_has_chunk     (o_has_chunk),
        .o_ok            (o_ok),
        .o_last          (o_last),
        .o_used_bytes    (o_used_bytes),
        .o_swapped_bytes (o_swapped_bytes)
    );

endmodule

`default_nettype wire

// File: src/ccep_dp.sv
// ----------------------------------------------------------------------------
// ccep_dp
// Datapath: link/size memories, marks, totals, sweep arithmetic, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module ccep_dp import ccep_pkg::*; #(
    parameter int CHUNKS    = DEF_CHUNKS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [4:0]  i_chunk_id,
    input  wire logic [31:0] i_chunk_size,
    input  wire logic [31:0] i_min_free,
    input  wire t_dp_op      i_op,
    output t_dp_status       o_st,
    output logic             o_valid,
    output logic [4:0]       o_evicted_chunk,
    output logic             o_has_chunk,
    output logic             o_ok,
    output logic             o_last,
    output logic [31:0]      o_used_bytes,
    output logic [31:0]      o_swapped_bytes
);

    localparam int SW = $clog2(CHUNKS);
    localparam int CW = $clog2(CHUNKS + 1);
    localparam int VW = (SIZE_BITS > 32) ? SIZE_BITS : 32;
    localparam logic [SIZE_BITS-1:0] SMAX = {SIZE_BITS{1'b1}};

    function automatic logic [SIZE_BITS-1:0] sat_add(input logic [SIZE_BITS-1:0] a,
                                                     input logic [SIZE_BITS-1:0] b);
        logic [SIZE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SIZE_BITS] ? SMAX : s[SIZE_BITS-1:0];
    endfunction

    function automatic logic [SIZE_BITS-1:0] floor_sub(input logic [SIZE_BITS-1:0] a,
                                                       input logic [SIZE_BITS-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    // configuration
    logic [31:0] r_limit;
    logic [8:0]  r_frac;

    // latched request
    logic [2:0]           r_req;
    logic [SW-1:0]        r_id;
    logic                 r_bad_id;
    logic [SIZE_BITS-1:0] r_size;
    logic [31:0]          r_min;

    // memories and read data
    logic [SW-1:0]        r_next_mem [CHUNKS];
    logic [SW-1:0]        r_prev_mem [CHUNKS];
    logic [SIZE_BITS-1:0] r_size_mem [CHUNKS];
    logic [SW-1:0]        r_next_q;
    logic [SW-1:0]        r_prev_q;
    logic [SIZE_BITS-1:0] r_size_q;

    // ring control state
    logic [CHUNKS-1:0]    r_valid;
    logic [CHUNKS-1:0]    r_swapped;
    logic [SW-1:0]        r_head;
    logic [SW-1:0]        r_hand;
    logic                 r_empty;
    logic [SIZE_BITS-1:0] r_res;
    logic [SIZE_BITS-1:0] r_swp;

    // working registers
    logic [SW-1:0]        r_before;
    logic [SW-1:0]        r_cur;
    logic [SW-1:0]        r_from;
    logic [SIZE_BITS-1:0] r_sum;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_emitted;
    logic [31:0]          r_tgt;
    logic [VW-1:0]        r_need;

    // result registers
    logic                 r_o_valid;
    logic [4:0]           r_o_evicted;
    logic                 r_o_has;
    logic                 r_o_ok;
    logic                 r_o_last;

    // memory port controls
    logic [SW-1:0]        rd_addr;
    logic                 next_we, prev_we, size_we;
    logic [SW-1:0]        next_wa, next_wd, prev_wa, prev_wd;

    // arithmetic
    logic [8:0]           frac_c;
    logic [32:0]          prod_hi;
    logic [16:0]          prod_lo;
    logic [31:0]          n_tgt;
    logic [VW-1:0]        res_ext, tgt_ext, min_ext, diff, n_need;
    logic                 cur_res;
    logic                 id_single;

    assign frac_c  = (r_frac > FRAC_FULL) ? FRAC_FULL : r_frac;
    assign prod_hi = 33'(r_limit[31:8]) * 33'(frac_c);
    assign prod_lo = 17'(r_limit[7:0]) * 17'(frac_c);
    assign n_tgt   = 32'(prod_hi + 33'(prod_lo[16:8]));

    assign res_ext = VW'(r_res);
    assign tgt_ext = VW'(r_tgt);
    assign min_ext = VW'(r_min);
    assign diff    = (res_ext > tgt_ext) ? res_ext - tgt_ext : '0;
    assign n_need  = (diff < min_ext) ? min_ext : diff;

    assign cur_res   = !r_swapped[r_cur];
    assign id_single = (r_next_q == r_id);

    always_comb begin
        o_st.is_reg       = (r_req == REQ_REGISTER);
        o_st.is_del       = (r_req == REQ_DELETE);
        o_st.is_tch       = (r_req == REQ_TOUCH);
        o_st.is_out       = (r_req == REQ_SWAP_OUT);
        o_st.is_in        = (r_req == REQ_SWAP_IN);
        o_st.bad_id       = r_bad_id;
        o_st.id_valid     = r_valid[r_id];
        o_st.id_swapped   = r_swapped[r_id];
        o_st.head_is_id   = (r_head == r_id);
        o_st.empty        = r_empty;
        o_st.min_gt_limit = (r_min > r_limit);
        o_st.need_zero    = (r_need == '0);
        o_st.sum_reached  = (VW'(r_sum) >= r_need);
        o_st.wrap         = (r_prev_q == r_from);
        o_st.cnt_zero     = (r_cnt == '0);
        o_st.emit_last    = cur_res && (CW'(r_emitted + CW'(1)) == r_cnt);
    end

    always_comb begin
        unique case (i_op)
            OP_REG_START, OP_RD_HEAD:     rd_addr = r_head;
            OP_RD_ID:                     rd_addr = r_id;
            OP_SWEEP_INIT:                rd_addr = r_hand;
            OP_SWEEP_STEP, OP_EMIT:       rd_addr = r_prev_q;
            OP_COMMIT:                    rd_addr = r_from;
            default:                      rd_addr = r_cur;
        endcase
    end

    always_comb begin
        next_we = 1'b0;
        prev_we = 1'b0;
        size_we = 1'b0;
        next_wa = r_id;
        next_wd = r_id;
        prev_wa = r_id;
        prev_wd = r_id;
        unique case (i_op)
            OP_REG_FIRST: begin
                next_we = 1'b1;
                prev_we = 1'b1;
                size_we = 1'b1;
            end
            OP_REG_START: begin
                size_we = 1'b1;
            end
            OP_INS_A: begin
                next_we = 1'b1;
                next_wa = r_prev_q;
                prev_we = 1'b1;
                prev_wa = r_head;
            end
            OP_INS_B: begin
                next_we = 1'b1;
                next_wd = r_head;
                prev_we = 1'b1;
                prev_wd = r_before;
            end
            OP_DEL, OP_TCH_UNLINK: begin
                // unlink: prev[n] = p, next[p] = n
                next_we = !(i_op == OP_DEL && id_single);
                next_wa = r_prev_q;
                next_wd = r_next_q;
                prev_we = !(i_op == OP_DEL && id_single);
                prev_wa = r_next_q;
                prev_wd = r_prev_q;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
        if (size_we) begin
            r_size_mem[r_id] <= r_size;
        end
        r_next_q <= r_next_mem[rd_addr];
        r_prev_q <= r_prev_mem[rd_addr];
        r_size_q <= r_size_mem[rd_addr];
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RESET;
            r_frac    <= FRAC_RESET;
            r_valid   <= '0;
            r_swapped <= '0;
            r_head    <= '0;
            r_hand    <= '0;
            r_empty   <= 1'b1;
            r_res     <= '0;
            r_swp     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MEMORY_LIMIT:      r_limit <= i_cfg_data;
                    CFG_SWAP_OUT_FRACTION: r_frac  <= i_cfg_data[8:0];
                endcase
            end
            r_o_valid <= (i_op == OP_RESP_OK) || (i_op == OP_RESP_FAIL)
                         || ((i_op == OP_EMIT) && cur_res);
            unique case (i_op)
                OP_REG_FIRST: begin
                    r_valid[r_id]   <= 1'b1;
                    r_swapped[r_id] <= 1'b0;
                    r_res           <= sat_add(r_res, r_size);
                    r_head          <= r_id;
                    r_hand          <= r_id;
                    r_empty         <= 1'b0;
                end
                OP_REG_START: begin
                    r_valid[r_id]   <= 1'b1;
                    r_swapped[r_id] <= 1'b0;
                    r_res           <= sat_add(r_res, r_size);
                end
                OP_INS_B: begin
                    r_head <= r_id;
                end
                OP_DEL: begin
                    if (r_swapped[r_id]) begin
                        r_swp <= floor_sub(r_swp, r_size_q);
                    end else begin
                        r_res <= floor_sub(r_res, r_size_q);
                    end
                    if (id_single) begin
                        r_empty <= 1'b1;
                        r_head  <= '0;
                        r_hand  <= '0;
                    end else begin
                        if (r_head == r_id) begin
                            r_head <= r_next_q;
                        end
                        if (r_hand == r_id) begin
                            r_hand <= r_prev_q;
                        end
                    end
                    r_valid[r_id]   <= 1'b0;
                    r_swapped[r_id] <= 1'b0;
                end
                OP_TCH_UNLINK: begin
                    if (r_hand == r_id) begin
                        r_hand <= r_prev_q;
                    end
                end
                OP_SWI: begin
                    r_swapped[r_id] <= 1'b0;
                    r_res           <= sat_add(r_res, r_size_q);
                    r_swp           <= floor_sub(r_swp, r_size_q);
                end
                OP_COMMIT: begin
                    r_res  <= floor_sub(r_res, r_sum);
                    r_swp  <= sat_add(r_swp, r_sum);
                    r_hand <= r_cur;
                end
                OP_EMIT: begin
                    if (cur_res) begin
                        r_swapped[r_cur] <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_req    <= i_req_type;
                r_id     <= SW'(i_chunk_id);
                r_bad_id <= (32'(i_chunk_id) >= 32'(CHUNKS));
                r_size   <= SIZE_BITS'(i_chunk_size);
                r_min    <= i_min_free;
            end
            OP_INS_A:      r_before <= r_prev_q;
            OP_CALC_TGT:   r_tgt    <= n_tgt;
            OP_CALC_NEED:  r_need   <= n_need;
            OP_SWEEP_INIT: begin
                r_cur  <= r_hand;
                r_from <= r_hand;
                r_sum  <= '0;
                r_cnt  <= '0;
            end
            OP_SWEEP_STEP: begin
                if (cur_res) begin
                    r_sum <= sat_add(r_sum, r_size_q);
                    r_cnt <= CW'(r_cnt + CW'(1));
                end
                r_cur <= r_prev_q;
            end
            OP_COMMIT: begin
                r_cur     <= r_from;
                r_emitted <= '0;
            end
            OP_EMIT: begin
                if (cur_res) begin
                    r_emitted   <= CW'(r_emitted + CW'(1));
                    r_o_evicted <= 5'(r_cur);
                    r_o_has     <= 1'b1;
                    r_o_ok      <= 1'b1;
                    r_o_last    <= o_st.emit_last;
                end
                r_cur <= r_prev_q;
            end
            OP_RESP_OK, OP_RESP_FAIL: begin
                r_o_evicted <= '0;
                r_o_has     <= 1'b0;
                r_o_ok      <= (i_op == OP_RESP_OK);
                r_o_last    <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_valid         = r_o_valid;
    assign o_evicted_chunk = r_o_evicted;
    assign o_has_chunk     = r_o_has;
    assign o_ok            = r_o_ok;
    assign o_last          = r_o_last;
    assign o_used_bytes    = 32'(r_res);
    assign o_swapped_bytes = 32'(r_swp);

endmodule

`default_nettype wire

// File: src/ccep_ctrl.sv
// ----------------------------------------------------------------------------
// ccep_ctrl
// Controller: sequences each request through datapath operations.
// ----------------------------------------------------------------------------
`default_nettype none

module ccep_ctrl import ccep_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_dp_status i_st,
    output t_dp_op          o_op,
    output logic            o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                priority if (i_st.is_out) begin
                    n_state = (i_st.empty || i_st.min_gt_limit) ? ST_RESP_FAIL : ST_CALC_TGT;
                end else if (i_st.bad_id) begin
                    n_state = ST_RESP_FAIL;
                end else if (i_st.is_reg) begin
                    priority if (i_st.id_valid) n_state = ST_RESP_FAIL;
                    else if (i_st.empty)        n_state = ST_RESP_OK;
                    else                        n_state = ST_INS_A;
                end else if (!(i_st.is_del || i_st.is_tch || i_st.is_in) || !i_st.id_valid) begin
                    n_state = ST_RESP_FAIL;
                end else if (i_st.is_del) begin
                    n_state = ST_DEL;
                end else if (i_st.is_tch) begin
                    n_state = i_st.head_is_id ? ST_RESP_OK : ST_TCH;
                end else begin
                    n_state = i_st.id_swapped ? ST_SWI : ST_RESP_FAIL;
                end
            end
            ST_INS_A:      n_state = ST_INS_B;
            ST_INS_B:      n_state = ST_RESP_OK;
            ST_DEL:        n_state = ST_RESP_OK;
            ST_TCH:        n_state = ST_TCH_RD;
            ST_TCH_RD:     n_state = ST_INS_A;
            ST_SWI:        n_state = ST_RESP_OK;
            ST_CALC_TGT:   n_state = ST_CALC_NEED;
            ST_CALC_NEED:  n_state = ST_SWEEP_INIT;
            ST_SWEEP_INIT: n_state = i_st.need_zero ? ST_RESP_OK : ST_SWEEP;
            ST_SWEEP: begin
                priority if (i_st.sum_reached) begin
                    n_state = i_st.cnt_zero ? ST_RESP_OK : ST_EMIT;
                end else if (i_st.wrap) begin
                    n_state = ST_RESP_FAIL;
                end else begin
                    n_state = ST_SWEEP;
                end
            end
            ST_EMIT: begin
                if (i_st.emit_last) n_state = ST_IDLE;
            end
            ST_RESP_OK:    n_state = ST_IDLE;
            ST_RESP_FAIL:  n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_op = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) o_op = OP_LOAD;
            end
            ST_DECODE: begin
                if (!i_st.is_out && !i_st.bad_id) begin
                    priority if (i_st.is_reg) begin
                        if (!i_st.id_valid) o_op = i_st.empty ? OP_REG_FIRST : OP_REG_START;
                    end else if (i_st.id_valid && (i_st.is_del || i_st.is_in
                                 || (i_st.is_tch && !i_st.head_is_id))) begin
                        o_op = OP_RD_ID;
                    end else begin
                        o_op = OP_NONE;
                    end
                end
            end
            ST_INS_A:      o_op = OP_INS_A;
            ST_INS_B:      o_op = OP_INS_B;
            ST_DEL:        o_op = OP_DEL;
            ST_TCH:        o_op = OP_TCH_UNLINK;
            ST_TCH_RD:     o_op = OP_RD_HEAD;
            ST_SWI:        o_op = OP_SWI;
            ST_CALC_TGT:   o_op = OP_CALC_TGT;
            ST_CALC_NEED:  o_op = OP_CALC_NEED;
            ST_SWEEP_INIT: o_op = i_st.need_zero ? OP_NONE : OP_SWEEP_INIT;
            ST_SWEEP: begin
                priority if (i_st.sum_reached) o_op = OP_COMMIT;
                else if (!i_st.wrap)           o_op = OP_SWEEP_STEP;
                else                           o_op = OP_NONE;
            end
            ST_EMIT:       o_op = OP_EMIT;
            ST_RESP_OK:    o_op = OP_RESP_OK;
            ST_RESP_FAIL:  o_op = OP_RESP_FAIL;
            default:       o_op = OP_NONE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chunk eviction policy block: a behavioral
// model of the recency ring predicts each result transaction, and a monitor
// compares the DUT output against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import ccep_pkg::*;

    // request codes the block must reject
    localparam logic [2:0] REQ_UNUSED_5 = 3'd5;
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    // slot picking modes
    localparam int PICK_FREE    = 0;
    localparam int PICK_LIVE    = 1;
    localparam int PICK_SWAPPED = 2;

    typedef struct packed {
        logic [4:0]  chunk;
        logic        has;
        logic        ok;
        logic        last;
        logic [31:0] used;
        logic [31:0] swapped;
    } t_evict_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic [2:0]  i_req_type = '0;
    logic [4:0]  i_chunk_id = '0;
    logic [31:0] i_chunk_size = '0;
    logic [31:0] i_min_free = '0;
    logic        o_valid;
    logic [4:0]  o_evicted_chunk;
    logic        o_has_chunk;
    logic        o_ok;
    logic        o_last;
    logic [31:0] o_used_bytes;
    logic [31:0] o_swapped_bytes;

    cyclic_chunk_eviction_policy i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_chunk_id      (i_chunk_id),
        .i_chunk_size    (i_chunk_size),
        .i_min_free      (i_min_free),
        .o_valid         (o_valid),
        .o_evicted_chunk (o_evicted_chunk),
        .o_has_chunk     (o_has_chunk),
        .o_ok            (o_ok),
        .o_last          (o_last),
        .o_used_bytes    (o_used_bytes),
        .o_swapped_bytes (o_swapped_bytes)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Ring model: links, sizes, marks, head, hand, totals and config
    // ------------------------------------------------------------------
    logic [4:0]  ring_next [32];
    logic [4:0]  ring_prev [32];
    logic [31:0] chunk_bytes [32];
    bit          is_swapped [32];
    bit          is_live [32];
    logic [4:0]  head;
    logic [4:0]  hand;
    bit          ring_is_empty = 1'b1;
    logic [31:0] resident_bytes = '0;
    logic [31:0] swapped_bytes = '0;
    logic [31:0] mem_limit = LIMIT_RESET;
    logic [8:0]  out_frac = FRAC_RESET;

    t_evict_rsp  rsp_q[$];
    int          n_errors = 0;
    int          n_txn = 0;
    int          n_rsp = 0;
    int          n_evicted = 0;

    initial begin
        head = '0;
        hand = '0;
        for (int i = 0; i < 32; i++) begin
            is_swapped[i] = 1'b0;
            is_live[i] = 1'b0;
        end
    end

    function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sub_floor(logic [31:0] a, logic [31:0] b);
        return (a > b) ? a - b : 32'd0;
    endfunction

    task automatic push_rsp(logic [4:0] chunk, logic has, logic ok, logic last);
        rsp_q.push_back(t_evict_rsp'{chunk, has, ok, last, resident_bytes, swapped_bytes});
    endtask

    task automatic link_at_head(logic [4:0] s);
        logic [4:0] b;
        b = ring_prev[head];
        ring_next[b] = s;
        ring_prev[head] = s;
        ring_next[s] = head;
        ring_prev[s] = b;
        head = s;
    endtask

    task automatic unlink(logic [4:0] s);
        ring_prev[ring_next[s]] = ring_prev[s];
        ring_next[ring_prev[s]] = ring_next[s];
    endtask

    // swap-out: pick resident chunks behind the hand until enough is freed
    task automatic predict_swap_out(logic [31:0] min_bytes);
        logic [63:0] f;
        logic [63:0] target;
        logic [31:0] need;
        logic [31:0] sum;
        logic [4:0]  from;
        logic [4:0]  cur;
        logic [4:0]  p;
        t_evict_rsp  picks[$];
        sum = '0;
        if (ring_is_empty || min_bytes > mem_limit) begin
            push_rsp(5'd0, 1'b0, 1'b0, 1'b1);
            return;
        end
        f = (out_frac > FRAC_FULL) ? 64'd256 : 64'(out_frac);
        target = 64'(mem_limit >> 8) * f + ((64'(mem_limit & 32'hFF) * f) >> 8);
        need = (64'(resident_bytes) > target) ? 32'(64'(resident_bytes) - target) : 32'd0;
        if (need < min_bytes) need = min_bytes;
        if (need == 0) begin
            push_rsp(5'd0, 1'b0, 1'b1, 1'b1);
            return;
        end
        from = hand;
        cur = from;
        while (sum < need) begin
            if (!is_swapped[cur]) sum = sat_add32(sum, chunk_bytes[cur]);
            cur = ring_prev[cur];
            if (cur == from) begin
                // hand came all the way round: no change at all
                push_rsp(5'd0, 1'b0, 1'b0, 1'b1);
                return;
            end
        end
        resident_bytes = sub_floor(resident_bytes, sum);
        swapped_bytes = sat_add32(swapped_bytes, sum);
        hand = cur;
        for (p = from; p != cur; p = ring_prev[p]) begin
            if (!is_swapped[p]) begin
                is_swapped[p] = 1'b1;
                picks.push_back(t_evict_rsp'{p, 1'b1, 1'b1, 1'b0, resident_bytes,
                                             swapped_bytes});
            end
        end
        if (picks.size() == 0) begin
            push_rsp(5'd0, 1'b0, 1'b1, 1'b1);
            return;
        end
        picks[picks.size() - 1].last = 1'b1;
        n_evicted += picks.size();
        foreach (picks[k]) rsp_q.push_back(picks[k]);
    endtask

    task automatic predict_request(logic [2:0] req, logic [4:0] id, logic [31:0] bytes,
                                   logic [31:0] min_bytes);
        logic ok;
        ok = 1'b0;
        if (req == REQ_SWAP_OUT) begin
            predict_swap_out(min_bytes);
            return;
        end
        case (req)
            REQ_REGISTER: begin
                if (!is_live[id]) begin
                    is_live[id] = 1'b1;
                    is_swapped[id] = 1'b0;
                    chunk_bytes[id] = bytes;
                    resident_bytes = sat_add32(resident_bytes, bytes);
                    if (ring_is_empty) begin
                        ring_next[id] = id;
                        ring_prev[id] = id;
                        head = id;
                        hand = id;
                        ring_is_empty = 1'b0;
                    end else begin
                        link_at_head(id);
                    end
                    ok = 1'b1;
                end
            end
            REQ_DELETE: begin
                if (is_live[id]) begin
                    if (is_swapped[id])
                        swapped_bytes = sub_floor(swapped_bytes, chunk_bytes[id]);
                    else
                        resident_bytes = sub_floor(resident_bytes, chunk_bytes[id]);
                    if (ring_next[id] == id) begin
                        ring_is_empty = 1'b1;
                        head = '0;
                        hand = '0;
                    end else begin
                        unlink(id);
                        if (head == id) head = ring_next[id];
                        if (hand == id) hand = ring_prev[id];
                    end
                    is_live[id] = 1'b0;
                    is_swapped[id] = 1'b0;
                    ok = 1'b1;
                end
            end
            REQ_TOUCH: begin
                if (is_live[id]) begin
                    if (head != id) begin
                        if (hand == id) hand = ring_prev[id];
                        unlink(id);
                        link_at_head(id);
                    end
                    ok = 1'b1;
                end
            end
            REQ_SWAP_IN: begin
                if (is_live[id] && is_swapped[id]) begin
                    is_swapped[id] = 1'b0;
                    resident_bytes = sat_add32(resident_bytes, chunk_bytes[id]);
                    swapped_bytes = sub_floor(swapped_bytes, chunk_bytes[id]);
                    ok = 1'b1;
                end
            end
            default: ok = 1'b0;
        endcase
        push_rsp(5'd0, 1'b0, ok, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Called at a rising edge; leaves start high so back-to-back
    // transactions need no extra edge.
    task automatic send_req(logic [2:0] req, logic [4:0] id, logic [31:0] bytes,
                            logic [31:0] min_bytes);
        bit taken;
        start <= 1'b1;
        i_req_type <= req;
        i_chunk_id <= id;
        i_chunk_size <= bytes;
        i_min_free <= min_bytes;
        do begin
            @(negedge i_clk);
            taken = !busy;   // busy only moves on rising edges
            @(posedge i_clk);
        end while (!taken);
        predict_request(req, id, bytes, min_bytes);
        n_txn++;
    endtask

    task automatic idle_for(int n);
        if (n > 0) start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // mostly back-to-back or short gaps, now and then a long one
    task automatic random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) idle_for(0);
        else if (r < 90) idle_for($urandom_range(1, 3));
        else idle_for($urandom_range(10, 40));
    endtask

    // wait until every predicted result arrived and the block is idle
    task automatic drain();
        start <= 1'b0;
        wait (rsp_q.size() == 0);
        @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
    endtask

    // one write cycle; the task returns with i_cfg_we low again
    task automatic cfg_write(logic idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx == CFG_MEMORY_LIMIT) mem_limit = data;
        else out_frac = data[8:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [4:0] pick_slot(int mode);
        logic [4:0] s;
        for (int t = 0; t < 12; t++) begin
            s = 5'($urandom_range(0, 31));
            if (mode == PICK_FREE && !is_live[s]) return s;
            if (mode == PICK_LIVE && is_live[s]) return s;
            if (mode == PICK_SWAPPED && is_live[s] && is_swapped[s]) return s;
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Result monitor: outputs sampled mid-cycle, away from the edges
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_evict_rsp got;
        t_evict_rsp want;
        if (i_rst_n && o_valid) begin
            got = '{o_evicted_chunk, o_has_chunk, o_ok, o_last, o_used_bytes,
                    o_swapped_bytes};
            n_rsp++;
            if (rsp_q.size() == 0) begin
                $display("%0t unexpected result: expected none, actual chunk=%0d has=%0b",
                         " ok=%0b last=%0b used=%0d swapped=%0d",
                         $realtime, got.chunk, got.has, got.ok, got.last, got.used,
                         got.swapped);
                n_errors++;
            end else begin
                want = rsp_q.pop_front();
                if (got.chunk !== want.chunk || got.has !== want.has || got.ok !== want.ok ||
                    got.last !== want.last || got.used !== want.used ||
                    got.swapped !== want.swapped) begin
                    $display("%0t result mismatch: expected chunk=%0d has=%0b ok=%0b",
                             " last=%0b used=%0d swapped=%0d",
                             $realtime, want.chunk, want.has, want.ok, want.last, want.used,
                             want.swapped);
                    $display("%0t                   actual chunk=%0d has=%0b ok=%0b",
                             " last=%0b used=%0d swapped=%0d",
                             $realtime, got.chunk, got.has, got.ok, got.last, got.used,
                             got.swapped);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // reset defaults: limit 0, so any nonzero min_free fails; empty ring fails
    task automatic test_reset_state();
        send_req(REQ_SWAP_OUT, 5'd0, 32'd0, 32'd0);
        send_req(REQ_TOUCH, 5'd3, 32'd0, 32'd0);
    endtask

    task automatic test_directed_ops();
        send_req(REQ_REGISTER, 5'd31, 32'd100, 32'd0);
        send_req(REQ_REGISTER, 5'd0, 32'd200, 32'd0);
        send_req(REQ_REGISTER, 5'd5, 32'd50, 32'd0);
        send_req(REQ_REGISTER, 5'd5, 32'd77, 32'd0);          // occupied slot
        send_req(REQ_TOUCH, 5'd5, 32'd0, 32'd0);              // already head
        send_req(REQ_TOUCH, 5'd31, 32'd0, 32'd0);
        send_req(REQ_TOUCH, 5'd7, 32'd0, 32'd0);              // empty slot
        send_req(REQ_SWAP_IN, 5'd0, 32'd0, 32'd0);            // still resident
        send_req(REQ_UNUSED_5, 5'd0, 32'd0, 32'd0);
        send_req(REQ_UNUSED_6, 5'd1, 32'd0, 32'd0);
        send_req(REQ_UNUSED_7, 5'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(REQ_SWAP_OUT, 5'd0, 32'd0, 32'd1);           // min above limit
        send_req(REQ_SWAP_OUT, 5'd0, 32'd0, 32'd0);           // hand wraps
        drain();
        cfg_write(CFG_MEMORY_LIMIT, 32'd1000);
        cfg_write(CFG_SWAP_OUT_FRACTION, 32'(FRAC_FULL));
        send_req(REQ_SWAP_OUT, 5'd0, 32'd0, 32'd0);           // nothing needed
        send_req(REQ_SWAP_OUT, 5'd0, 32'd0, 32'd120);         // evicts
        send_req(REQ_SWAP_IN, 5'd31, 32'd0, 32'd0);
        send_req(REQ_DELETE, 5'd0, 32'd0, 32'd0);
        send_req(REQ_REGISTER, 5'd9, 32'hFFFF_FFFF, 32'd0);   // saturates total
        send_req(REQ_DELETE, 5'd9, 32'd0, 32'd0);
        send_req(REQ_DELETE, 5'd5, 32'd0, 32'd0);
        send_req(REQ_DELETE, 5'd31, 32'd0, 32'd0);            // last chunk
        send_req(REQ_DELETE, 5'd31, 32'd0, 32'd0);            // empty now
        drain();
    endtask

    task automatic random_request();
        int r;
        logic [31:0] bytes;
        logic [31:0] min_bytes;
        r = $urandom_range(0, 99);
        bytes = ($urandom_range(0, 9) == 0) ? $urandom :
                ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 4096));
        min_bytes = ($urandom_range(0, 6) == 0) ? $urandom :
                    ($urandom_range(0, 5) == 0) ? 32'd0 : 32'($urandom_range(0, 3000));
        if (r < 28)
            send_req(REQ_REGISTER, pick_slot($urandom_range(0, 9) ? PICK_FREE : PICK_LIVE),
                     bytes, min_bytes);
        else if (r < 40)
            send_req(REQ_DELETE, pick_slot($urandom_range(0, 9) ? PICK_LIVE : PICK_FREE),
                     bytes, min_bytes);
        else if (r < 56)
            send_req(REQ_TOUCH, ($urandom_range(0, 4) == 0) ? head :
                     pick_slot($urandom_range(0, 9) ? PICK_LIVE : PICK_FREE), bytes, min_bytes);
        else if (r < 76)
            send_req(REQ_SWAP_OUT, 5'($urandom), bytes, min_bytes);
        else if (r < 95)
            send_req(REQ_SWAP_IN, pick_slot($urandom_range(0, 5) ? PICK_SWAPPED : PICK_LIVE),
                     bytes, min_bytes);
        else
            send_req(3'($urandom_range(REQ_UNUSED_5, REQ_UNUSED_7)), 5'($urandom), bytes,
                     min_bytes);
    endtask

    // four settings of the two registers, extremes included
    task automatic test_random_phases();
        logic [31:0] limits [4];
        logic [8:0]  fracs [4];
        limits = '{32'($urandom_range(0, 40000)), 32'hFFFF_FFFF, 32'd0, $urandom};
        fracs = '{9'd0, 9'($urandom_range(0, 511)), 9'd511, FRAC_RESET};
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            cfg_write(CFG_MEMORY_LIMIT, limits[ph]);
            cfg_write(CFG_SWAP_OUT_FRACTION, 32'(fracs[ph]));
            for (int k = 0; k < 36; k++) begin
                random_request();
                random_gap();
                if (ph == 1 && k == 18) drain();   // sender holds off until all is back
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed_ops();
        test_random_phases();
        drain();
        repeat (80) @(posedge i_clk);
        $display("Ran %0d request transactions with %0d results, %0d of them evictions,",
                 n_txn, n_rsp, n_evicted);
        $display("over four limit and fraction settings plus directed corner requests.");
        if (n_errors == 0 && rsp_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout waiting for results");
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
src/ccep_pkg.sv
src/ccep_dp.sv
src/ccep_ctrl.sv
src/cyclic_chunk_eviction_policy.sv
tb/sv/tb.sv
